>>> src/gdfs_pkg.sv
// Package for the grid depth-first maze solver.
// Holds the transaction structs, cell and stack widths, register indexes and direction codes.
// No dependencies.
package gdfs_pkg;

    localparam int CELL_W      = 6;
    localparam int COORD_W     = 3;
    localparam int DIM_W       = 4;
    localparam int CELLS       = 64;
    localparam int STACK_DEPTH = 256;
    localparam int STACK_AW    = 8;
    localparam int STACK_CNT_W = 9;
    localparam int TRACE_W     = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;

    typedef logic [CELL_W-1:0]  cell_idx_t;
    typedef logic [COORD_W-1:0] coord_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_IN_USE = 3'd0,
        REG_COLS_IN_USE = 3'd1,
        REG_START_ROW   = 3'd2,
        REG_START_COL   = 3'd3,
        REG_EXIT_ROW    = 3'd4,
        REG_EXIT_COL    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_DOWN  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    localparam logic KIND_WALL  = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    typedef struct packed {
        logic   kind;
        coord_t cell_row;
        coord_t cell_col;
        logic   is_wall;
    } in_item_t;

    typedef struct packed {
        logic   found;
        coord_t path_row;
        coord_t path_col;
        logic   last;
    } out_item_t;

endpackage

>>> src/gdfs_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Used for every store of the maze solver. No dependencies.
module gdfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/grid_dfs_path_finder.sv
// Depth-first maze solver over a grid of up to GRID_ROWS x GRID_COLS cells.
// A wall transaction is taken in idle and written to the wall map. After reset the wall
// and visited maps are swept clear, cell by cell, and no input transaction is taken
// meanwhile. A solve first clears the visited map, then runs the search: each popped
// cell passes through the pop, pop-wait and visited-check states, and one not yet visited
// then steps through each direction and reads the wall and visited maps of each in-bounds
// neighbour, limited by the single read port of each store. The path is then traced back
// from the exit through the parent store, one item per path cell and a last one for the
// start cell; a solve with no path gives one item with found low. Results wait in an
// output register, and the next input transaction is taken once the solve finishes.
module grid_dfs_path_finder #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  gdfs_pkg::in_item_t          s_payload,
    output logic                        m_valid,
    input  logic                        m_ready,
    output gdfs_pkg::out_item_t         m_payload,
    input  logic                        cfg_we,
    input  logic [gdfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gdfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import gdfs_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLEAR = 10'b0000000010,
        ST_POP   = 10'b0000000100,
        ST_POPW  = 10'b0000001000,
        ST_VCHK  = 10'b0000010000,
        ST_NB    = 10'b0000100000,
        ST_NBW   = 10'b0001000000,
        ST_TR    = 10'b0010000000,
        ST_TRW   = 10'b0100000000,
        ST_FAIL  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0] rows_reg, cols_reg;
    coord_t start_row_reg, start_col_reg, exit_row_reg, exit_col_reg;

    logic [CELL_W-1:0]      clr_idx_reg, clr_idx_next;
    logic                   clr_wall_reg, clr_wall_next;
    logic [STACK_CNT_W-1:0] stack_cnt_reg, stack_cnt_next;
    cell_idx_t              cur_reg, cur_next;
    cell_idx_t              nb_reg, nb_next;
    dir_t                   dir_reg, dir_next;
    logic [TRACE_W-1:0]     trace_cnt_reg, trace_cnt_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_payload_reg, m_payload_next;

    logic                   wall_we, wall_wdata, wall_rdata;
    cell_idx_t              wall_waddr;
    logic                   vis_we, vis_wdata, vis_rdata;
    cell_idx_t              vis_waddr, vis_raddr;
    logic                   stk_we;
    logic [STACK_AW-1:0]    stk_waddr, stk_raddr;
    cell_idx_t              stk_wdata, stk_rdata;
    logic                   par_we;
    cell_idx_t              par_rdata;

    logic [DIM_W-1:0]       h_eff, w_eff;
    logic [STACK_CNT_W-1:0] cnt_dec;
    logic                   nb_ok, out_free, start_ok, wall_in_grid;
    coord_t                 cur_r, cur_c, nb_r, nb_c;
    cell_idx_t              nb_idx, start_idx;

    gdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall_ram (
        .aclk  (aclk),
        .we    (wall_we),
        .waddr (wall_waddr),
        .wdata (wall_wdata),
        .raddr (nb_idx),
        .rdata (wall_rdata)
    );

    gdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
        .aclk  (aclk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    gdfs_ram #(.WIDTH(CELL_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    gdfs_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent_ram (
        .aclk  (aclk),
        .we    (par_we),
        .waddr (nb_reg),
        .wdata (cur_reg),
        .raddr (cur_reg),
        .rdata (par_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        if (rows_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (rows_reg > DIM_W'(GRID_ROWS)) begin
            h_eff = DIM_W'(GRID_ROWS);
        end else begin
            h_eff = rows_reg;
        end
        if (cols_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (cols_reg > DIM_W'(GRID_COLS)) begin
            w_eff = DIM_W'(GRID_COLS);
        end else begin
            w_eff = cols_reg;
        end
    end

    assign start_ok     = ({1'b0, start_row_reg} < h_eff) && ({1'b0, start_col_reg} < w_eff);
    assign start_idx    = {start_row_reg, start_col_reg};
    assign wall_in_grid = ({1'b0, s_payload.cell_row} < DIM_W'(GRID_ROWS))
                       && ({1'b0, s_payload.cell_col} < DIM_W'(GRID_COLS));
    assign cnt_dec      = stack_cnt_reg - STACK_CNT_W'(1);
    assign cur_r        = cur_reg[CELL_W-1:COORD_W];
    assign cur_c        = cur_reg[COORD_W-1:0];

    always_comb begin
        nb_r  = cur_r;
        nb_c  = cur_c;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_UP: begin
                nb_r  = cur_r - COORD_W'(1);
                nb_ok = (cur_r != '0);
            end
            DIR_LEFT: begin
                nb_c  = cur_c - COORD_W'(1);
                nb_ok = (cur_c != '0);
            end
            DIR_DOWN: begin
                nb_r  = cur_r + COORD_W'(1);
                nb_ok = (({1'b0, cur_r} + DIM_W'(1)) < h_eff);
            end
            DIR_RIGHT: begin
                nb_c  = cur_c + COORD_W'(1);
                nb_ok = (({1'b0, cur_c} + DIM_W'(1)) < w_eff);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign nb_idx = {nb_r, nb_c};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg      <= DIM_W'(8);
            cols_reg      <= DIM_W'(8);
            start_row_reg <= '0;
            start_col_reg <= '0;
            exit_row_reg  <= COORD_W'(7);
            exit_col_reg  <= COORD_W'(7);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS_IN_USE: rows_reg      <= cfg_wdata;
                REG_COLS_IN_USE: cols_reg      <= cfg_wdata;
                REG_START_ROW:   start_row_reg <= cfg_wdata[COORD_W-1:0];
                REG_START_COL:   start_col_reg <= cfg_wdata[COORD_W-1:0];
                REG_EXIT_ROW:    exit_row_reg  <= cfg_wdata[COORD_W-1:0];
                REG_EXIT_COL:    exit_col_reg  <= cfg_wdata[COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        clr_wall_next  = clr_wall_reg;
        stack_cnt_next = stack_cnt_reg;
        cur_next       = cur_reg;
        nb_next        = nb_reg;
        dir_next       = dir_reg;
        trace_cnt_next = trace_cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        wall_we    = 1'b0;
        wall_waddr = {s_payload.cell_row, s_payload.cell_col};
        wall_wdata = s_payload.is_wall;
        vis_we     = 1'b0;
        vis_waddr  = clr_idx_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = (state_reg == ST_POPW) ? stk_rdata : nb_idx;
        stk_we     = 1'b0;
        stk_waddr  = stack_cnt_reg[STACK_AW-1:0];
        stk_wdata  = nb_reg;
        stk_raddr  = cnt_dec[STACK_AW-1:0];
        par_we     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.kind == KIND_SOLVE) begin
                        clr_idx_next  = '0;
                        clr_wall_next = 1'b0;
                        state_next    = ST_CLEAR;
                    end else begin
                        wall_we = wall_in_grid;
                    end
                end
            end
            ST_CLEAR: begin
                vis_we       = 1'b1;
                wall_we      = clr_wall_reg;
                wall_waddr   = clr_idx_reg;
                wall_wdata   = 1'b0;
                clr_idx_next = clr_idx_reg + CELL_W'(1);
                if (clr_idx_reg == CELL_W'(CELLS - 1)) begin
                    if (clr_wall_reg) begin
                        state_next = ST_IDLE;
                    end else if (start_ok) begin
                        stk_we         = 1'b1;
                        stk_waddr      = '0;
                        stk_wdata      = start_idx;
                        stack_cnt_next = STACK_CNT_W'(1);
                        state_next     = ST_POP;
                    end else begin
                        state_next = ST_FAIL;
                    end
                end
            end
            ST_POP: begin
                if (stack_cnt_reg == '0) begin
                    state_next = ST_FAIL;
                end else begin
                    stack_cnt_next = cnt_dec;
                    state_next     = ST_POPW;
                end
            end
            ST_POPW: begin
                cur_next   = stk_rdata;
                state_next = ST_VCHK;
            end
            ST_VCHK: begin
                if (vis_rdata) begin
                    state_next = ST_POP;
                end else begin
                    vis_we    = 1'b1;
                    vis_waddr = cur_reg;
                    vis_wdata = 1'b1;
                    if (cur_reg == {exit_row_reg, exit_col_reg}) begin
                        trace_cnt_next = '0;
                        state_next     = ST_TR;
                    end else begin
                        dir_next   = DIR_UP;
                        state_next = ST_NB;
                    end
                end
            end
            ST_NB: begin
                nb_next = nb_idx;
                if (nb_ok) begin
                    state_next = ST_NBW;
                end else if (dir_reg == DIR_RIGHT) begin
                    state_next = ST_POP;
                end else begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NBW: begin
                if (!wall_rdata && !vis_rdata) begin
                    par_we = 1'b1;
                    if (stack_cnt_reg < STACK_CNT_W'(STACK_DEPTH)) begin
                        stk_we         = 1'b1;
                        stack_cnt_next = stack_cnt_reg + STACK_CNT_W'(1);
                    end
                end
                if (dir_reg == DIR_RIGHT) begin
                    state_next = ST_POP;
                end else begin
                    dir_next   = dir_t'(dir_reg + 2'd1);
                    state_next = ST_NB;
                end
            end
            ST_TR: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_payload_next.found    = 1'b1;
                    if (cur_reg == start_idx || trace_cnt_reg == TRACE_W'(CELLS - 1)) begin
                        m_payload_next.path_row = start_row_reg;
                        m_payload_next.path_col = start_col_reg;
                        m_payload_next.last     = 1'b1;
                        state_next              = ST_IDLE;
                    end else begin
                        m_payload_next.path_row = cur_r;
                        m_payload_next.path_col = cur_c;
                        m_payload_next.last     = 1'b0;
                        trace_cnt_next          = trace_cnt_reg + TRACE_W'(1);
                        state_next              = ST_TRW;
                    end
                end
            end
            ST_TRW: begin
                cur_next   = par_rdata;
                state_next = ST_TR;
            end
            ST_FAIL: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_payload_next.found    = 1'b0;
                    m_payload_next.path_row = '0;
                    m_payload_next.path_col = '0;
                    m_payload_next.last     = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clr_wall_reg  <= 1'b1;
            stack_cnt_reg <= '0;
            dir_reg       <= DIR_UP;
            trace_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            clr_wall_reg  <= clr_wall_next;
            stack_cnt_reg <= stack_cnt_next;
            dir_reg       <= dir_next;
            trace_cnt_reg <= trace_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        nb_reg        <= nb_next;
        m_payload_reg <= m_payload_next;
    end

endmodule
